// ===== hdl/tspu_pkg.sv =====
// ----------------------------------------------------------------------------
// tspu_pkg
// Shared constants, codes and types of the scanline pixel unpacker.
// ----------------------------------------------------------------------------
package tspu_pkg;

    // image size limits and derived counter widths
    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int COL_W         = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W         = $clog2(MAX_HEIGHT + 1);
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

    // short queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // register indexes
    localparam logic [2:0] REG_BITS_PER_SAMPLE   = 3'd0;
    localparam logic [2:0] REG_PHOTOMETRIC_MODE  = 3'd1;
    localparam logic [2:0] REG_SAMPLES_PER_PIXEL = 3'd2;
    localparam logic [2:0] REG_IMAGE_WIDTH       = 3'd3;
    localparam logic [2:0] REG_IMAGE_HEIGHT      = 3'd4;

    // photometric modes
    localparam logic [1:0] MODE_MIN_IS_WHITE = 2'd0;
    localparam logic [1:0] MODE_MIN_IS_BLACK = 2'd1;
    localparam logic [1:0] MODE_RGB          = 2'd2;
    localparam logic [1:0] MODE_PALETTE      = 2'd3;

    // item operations
    localparam logic OP_DATA    = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    // samples per pixel that carries a skipped alpha sample
    localparam logic [2:0] SPP_WITH_ALPHA = 3'd4;

    // full-byte sample width
    localparam logic [3:0] BYTE_BITS = 4'd8;

    typedef struct packed {
        logic [3:0]  bits_per_sample;
        logic [1:0]  photometric_mode;
        logic [2:0]  samples_per_pixel;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } t_cfg;

    // classified item: key is the scanline byte or the palette index
    typedef struct packed {
        logic        op;
        logic [7:0]  key;
        logic [23:0] rgb;
    } t_queue_entry;

endpackage

// ===== hdl/tspu_intf.sv =====
// ----------------------------------------------------------------------------
// tspu_intf
// Valid/ready channels carrying input items and pixel results.
// ----------------------------------------------------------------------------
interface tspu_in_if import tspu_pkg::*; ();
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;

    modport source (
        output valid, op, data_byte, palette_index, red_level, green_level, blue_level,
        input  ready
    );
    modport sink (
        input  valid, op, data_byte, palette_index, red_level, green_level, blue_level,
        output ready
    );
endinterface

interface tspu_out_if import tspu_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] first_value;
    logic [7:0] second_value;
    logic [7:0] third_value;
    logic       last_in_row;
    logic       last_in_image;

    modport source (
        output valid, first_value, second_value, third_value, last_in_row, last_in_image,
        input  ready
    );
    modport sink (
        input  valid, first_value, second_value, third_value, last_in_row, last_in_image,
        output ready
    );
endinterface

// ===== hdl/tspu_front.sv =====
// ----------------------------------------------------------------------------
// tspu_front
// Accepts input items, classifies them and scales palette levels to 8 bits.
// ----------------------------------------------------------------------------
module tspu_front import tspu_pkg::*; (
    tspu_in_if.sink      i_in,
    input  logic         i_q_ready,
    output logic         o_push,
    output t_queue_entry o_entry
);

    // floor(level * 255 / 65535) == floor(level / 257); with level = 256*h + l
    // the quotient is h when l >= h, else h - 1
    function automatic logic [7:0] scale_level(input logic [15:0] level);
        logic [7:0] hi;
        logic [7:0] lo;
        begin
            hi = level[15:8];
            lo = level[7:0];
            scale_level = (lo >= hi) ? hi : 8'(hi - 8'd1);
        end
    endfunction

    // accept whenever the queue has room
    assign i_in.ready = i_q_ready;
    assign o_push     = i_in.valid & i_q_ready;

    // classify item
    always_comb begin
        o_entry.op  = i_in.op;
        o_entry.key = (i_in.op == OP_PALETTE) ? i_in.palette_index : i_in.data_byte;
        o_entry.rgb = {scale_level(i_in.red_level), scale_level(i_in.green_level),
                       scale_level(i_in.blue_level)};
    end

endmodule

// ===== hdl/tspu_queue.sv =====
// ----------------------------------------------------------------------------
// tspu_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module tspu_queue import tspu_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_queue_entry i_entry,
    output logic         o_ready,
    input  logic         i_pop,
    output logic         o_valid,
    output t_queue_entry o_head
);

    t_queue_entry r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= QPTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= QPTR_W'(r_rd_ptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= QCNT_W'(r_count + 1'b1);
            end else if (!i_push && i_pop) begin
                r_count <= QCNT_W'(r_count - 1'b1);
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ===== hdl/tspu_back.sv =====
// ----------------------------------------------------------------------------
// tspu_back
// Unpacks one sample per cycle unless the output stalls, holds the palette and registers the pixels.
// ----------------------------------------------------------------------------
module tspu_back import tspu_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_head_valid,
    input  t_queue_entry i_head,
    output logic         o_pop,
    tspu_out_if.source   o_out
);

    // unpack state
    logic [3:0]       r_pos;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [1:0]       r_chan;
    logic [7:0]       r_red;
    logic [7:0]       r_green;

    // output stage
    logic        r_b_valid;
    logic        r_b_pal;
    logic [7:0]  r_v1;
    logic [7:0]  r_v2;
    logic [7:0]  r_v3;
    logic        r_lr;
    logic        r_li;
    logic [23:0] r_rd_data;

    logic [23:0] r_palette [PALETTE_DEPTH];

    logic [3:0]       bps;
    logic [7:0]       maxval;
    logic [COL_W-1:0] width_eff;
    logic [ROW_W-1:0] height_eff;
    logic [3:0]       bits_after;
    logic [7:0]       sample;
    logic [COL_W-1:0] col_inc;
    logic [ROW_W-1:0] row_inc;
    logic             last_col;
    logic             last_row;
    logic             emit;
    logic             done;
    logic [7:0]       v1;
    logic [7:0]       v2;
    logic [7:0]       v3;
    logic [1:0]       n_chan;
    logic [7:0]       n_red;
    logic [7:0]       n_green;
    logic             byte_done;
    logic             advance;
    logic             issue;
    logic             is_data;

    // effective sample width and image size
    always_comb begin
        bps = ((i_cfg.bits_per_sample == '0) || (i_cfg.bits_per_sample > BYTE_BITS))
              ? BYTE_BITS : i_cfg.bits_per_sample;
        maxval = 8'((9'd1 << bps) - 9'd1);
        if (i_cfg.image_width == '0) begin
            width_eff = COL_W'(1);
        end else if (i_cfg.image_width > COL_W'(MAX_WIDTH)) begin
            width_eff = COL_W'(MAX_WIDTH);
        end else begin
            width_eff = i_cfg.image_width;
        end
        if (i_cfg.image_height == '0) begin
            height_eff = ROW_W'(1);
        end else if (i_cfg.image_height > ROW_W'(MAX_HEIGHT)) begin
            height_eff = ROW_W'(MAX_HEIGHT);
        end else begin
            height_eff = i_cfg.image_height;
        end
    end

    // sample extraction and row position
    always_comb begin
        bits_after = 4'(r_pos - bps);
        sample     = 8'(i_head.key >> bits_after) & maxval;
        col_inc    = COL_W'(r_col + 1'b1);
        row_inc    = ROW_W'(r_row + 1'b1);
        last_col   = (col_inc >= width_eff);
        last_row   = (row_inc >= height_eff);
    end

    // per-mode pixel assembly
    always_comb begin
        emit    = 1'b0;
        done    = 1'b0;
        v1      = '0;
        v2      = '0;
        v3      = '0;
        n_chan  = r_chan;
        n_red   = r_red;
        n_green = r_green;
        case (i_cfg.photometric_mode)
            MODE_MIN_IS_WHITE: begin
                v1   = 8'(maxval - sample);
                emit = 1'b1;
                done = 1'b1;
            end
            MODE_MIN_IS_BLACK: begin
                v1   = sample;
                emit = 1'b1;
                done = 1'b1;
            end
            MODE_PALETTE: begin
                emit = 1'b1;
                done = 1'b1;
            end
            default: begin
                case (r_chan)
                    2'd0: begin
                        n_red  = sample;
                        n_chan = 2'd1;
                    end
                    2'd1: begin
                        n_green = sample;
                        n_chan  = 2'd2;
                    end
                    2'd2: begin
                        v1   = r_red;
                        v2   = r_green;
                        v3   = sample;
                        emit = 1'b1;
                        if (i_cfg.samples_per_pixel == SPP_WITH_ALPHA) begin
                            n_chan = 2'd3;
                        end else begin
                            done = 1'b1;
                        end
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
        endcase
        if (done) begin
            n_chan = 2'd0;
        end
    end

    // issue control: a byte leaves the queue after its last sample or at row end
    always_comb begin
        is_data   = (i_head.op == OP_DATA);
        byte_done = (done && last_col) || (bits_after < bps);
        advance   = !r_b_valid || o_out.ready;
        issue     = i_head_valid && advance;
        o_pop     = issue && (!is_data || byte_done);
    end

    // unpack state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= BYTE_BITS;
            r_col   <= '0;
            r_row   <= '0;
            r_chan  <= '0;
            r_red   <= '0;
            r_green <= '0;
        end else if (issue && is_data) begin
            r_pos   <= byte_done ? BYTE_BITS : bits_after;
            r_chan  <= n_chan;
            r_red   <= n_red;
            r_green <= n_green;
            if (done) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : row_inc;
                end else begin
                    r_col <= col_inc;
                end
            end
        end
    end

    // output stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (advance) begin
            r_b_valid <= issue && is_data && emit;
        end
    end

    // output stage payload
    always_ff @(posedge i_clk) begin
        if (issue && is_data && emit) begin
            r_b_pal <= (i_cfg.photometric_mode == MODE_PALETTE);
            r_v1    <= v1;
            r_v2    <= v2;
            r_v3    <= v3;
            r_lr    <= last_col;
            r_li    <= last_col && last_row;
        end
    end

    // palette memory: written by palette items, read by palette pixels
    always_ff @(posedge i_clk) begin
        if (issue && !is_data) begin
            r_palette[i_head.key[PAL_AW-1:0]] <= i_head.rgb;
        end
        if (issue && is_data && emit && (i_cfg.photometric_mode == MODE_PALETTE)) begin
            r_rd_data <= r_palette[sample[PAL_AW-1:0]];
        end
    end

    // result fields
    assign o_out.valid         = r_b_valid;
    assign o_out.first_value   = r_b_pal ? r_rd_data[23:16] : r_v1;
    assign o_out.second_value  = r_b_pal ? r_rd_data[15:8]  : r_v2;
    assign o_out.third_value   = r_b_pal ? r_rd_data[7:0]   : r_v3;
    assign o_out.last_in_row   = r_lr;
    assign o_out.last_in_image = r_li;

endmodule

// ===== hdl/tiff_scanline_pixel_unpacker.sv =====
// ----------------------------------------------------------------------------
// tiff_scanline_pixel_unpacker
// Unpacks TIFF scanline bytes into gray, rgb or palette pixels.
// ----------------------------------------------------------------------------
// Input channel i_in carries items: a scanline byte (op 0) or a palette entry
// write (op 1, 16-bit levels stored as 8-bit). Output channel o_out carries one
// item per completed pixel with last-in-row and last-in-image flags.
// The APB port sets sample width, photometric mode, samples per pixel and
// image size; write it only while the block is idle.
// A byte accepted at the input is written into the queue, unpacked from the
// queue head by the back, and its pixel is registered in the output stage.
// The back unpacks one sample per cycle unless the output stalls; a byte of
// sub-byte samples stays at the queue head until its last sample or row end.
// A 4-entry queue parts the front from the back: input is taken while a
// pixel waits in the output register; when the receiver stalls, the back
// holds and the queue fills before input ready drops.
// Reset (synchronous, active low) restores register defaults and clears the
// row, column and channel counters; palette entries are undefined until
// written.
// ----------------------------------------------------------------------------
module tiff_scanline_pixel_unpacker import tspu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    tspu_in_if.sink            i_in,
    tspu_out_if.source         o_out
);

    t_cfg         r_cfg;
    logic [2:0]   reg_index;
    logic         cfg_write;
    logic         q_ready;
    logic         push;
    t_queue_entry push_entry;
    logic         pop;
    logic         head_valid;
    t_queue_entry head;

    // register access decode
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bits_per_sample   <= BYTE_BITS;
            r_cfg.photometric_mode  <= MODE_MIN_IS_BLACK;
            r_cfg.samples_per_pixel <= 3'd1;
            r_cfg.image_width       <= 13'(MAX_WIDTH);
            r_cfg.image_height      <= 13'(MAX_HEIGHT);
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_BITS_PER_SAMPLE:   r_cfg.bits_per_sample   <= pwdata[3:0];
                REG_PHOTOMETRIC_MODE:  r_cfg.photometric_mode  <= pwdata[1:0];
                REG_SAMPLES_PER_PIXEL: r_cfg.samples_per_pixel <= pwdata[2:0];
                REG_IMAGE_WIDTH:       r_cfg.image_width       <= pwdata[12:0];
                REG_IMAGE_HEIGHT:      r_cfg.image_height      <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_index)
            REG_BITS_PER_SAMPLE:   prdata = PDATA_W'(r_cfg.bits_per_sample);
            REG_PHOTOMETRIC_MODE:  prdata = PDATA_W'(r_cfg.photometric_mode);
            REG_SAMPLES_PER_PIXEL: prdata = PDATA_W'(r_cfg.samples_per_pixel);
            REG_IMAGE_WIDTH:       prdata = PDATA_W'(r_cfg.image_width);
            REG_IMAGE_HEIGHT:      prdata = PDATA_W'(r_cfg.image_height);
            default:               prdata = '0;
        endcase
    end

    // front: accept and classify
    tspu_front u_front (
        .i_in      (i_in),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    // queue between front and back
    tspu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head)
    );

    // back: unpack and emit pixels
    tspu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule
